// ===== rtl/msu_pkg.sv =====
// ----------------------------------------------------------------------------
// msu_pkg
// shared types and constants for the merge sort unit
// ----------------------------------------------------------------------------
`default_nettype none

package msu_pkg;

  localparam int unsigned DATA_W = 32;

  typedef logic signed [DATA_W-1:0] data_t;

  typedef enum logic [2:0] {
    S_LOAD,
    S_SETUP_I,
    S_SETUP_J,
    S_MERGE,
    S_EMIT,
    S_DRAIN
  } state_t;

endpackage

`default_nettype wire

// ===== rtl/msu_ram.sv =====
// ----------------------------------------------------------------------------
// msu_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module msu_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== rtl/merge_sort_unit.sv =====
// ----------------------------------------------------------------------------
// merge_sort_unit
// buffers a list of signed words and emits it in ascending order
// ----------------------------------------------------------------------------
// load: one beat per cycle while busy is low; beats past MAX_ITEMS are dropped
// sort: ceil(log2 n) bottom-up passes between two ping-pong rams,
//   one element per cycle in the merge state through the single read port
// emit: first result after the registered read in the emit state, then one result per cycle
// the receiver cannot stall
// reset clears control state only; ram contents are undefined until written
`default_nettype none

module merge_sort_unit #(
  parameter int unsigned MAX_ITEMS = 64
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  output      logic          busy,
  input  wire msu_pkg::data_t value,
  input  wire logic          last_in,
  output      logic          strobe,
  output      msu_pkg::data_t sorted_value,
  output      logic          last_out,
  output      logic          overflow
);

  import msu_pkg::*;

  localparam int unsigned AW = $clog2(MAX_ITEMS);
  localparam int unsigned CW = $clog2(MAX_ITEMS + 1);
  localparam int unsigned XW = CW + 2;

  state_t          state, state_next;
  logic [CW-1:0]   count, count_next;
  logic            ovf, ovf_next;
  logic            sel, sel_next;
  logic [XW-1:0]   width, width_next;
  logic [CW-1:0]   lo, lo_next;
  logic [CW-1:0]   mid, mid_next;
  logic [CW-1:0]   hi, hi_next;
  logic [CW-1:0]   i, i_next;
  logic [CW-1:0]   j, j_next;
  logic [CW-1:0]   k, k_next;
  data_t           head_i, head_i_next;
  data_t           head_j, head_j_next;
  logic            pend_i, pend_i_next;
  logic            pend_j, pend_j_next;
  logic            emit_v, emit_v_next;
  logic            emit_last, emit_last_next;

  logic            we0, we1;
  logic [AW-1:0]   waddr, raddr;
  data_t           wdata;
  data_t           rd0, rd1, rd_src;
  data_t           eff_i, eff_j;
  logic            i_left, j_left, take_i;
  logic            accept;
  logic [XW-1:0]   sum_mid, sum_hi, next_lo, width_dbl;

  msu_ram #(.WIDTH(DATA_W), .DEPTH(MAX_ITEMS)) u_ram0 (
    .clk(clk), .we(we0), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rd0)
  );

  msu_ram #(.WIDTH(DATA_W), .DEPTH(MAX_ITEMS)) u_ram1 (
    .clk(clk), .we(we1), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rd1)
  );

  assign busy         = (state != S_LOAD);
  assign accept       = start && !busy;
  assign rd_src       = sel ? rd1 : rd0;
  assign sorted_value = rd_src;
  assign strobe       = emit_v;
  assign last_out     = emit_last;
  assign overflow     = ovf;

  assign eff_i  = pend_i ? rd_src : head_i;
  assign eff_j  = pend_j ? rd_src : head_j;
  assign i_left = (i < mid);
  assign j_left = (j < hi);
  assign take_i = i_left && (!j_left || (eff_i < eff_j));

  assign sum_mid   = XW'(lo) + width;
  assign sum_hi    = XW'(lo) + (width << 1);
  assign next_lo   = XW'(lo) + (width << 1);
  assign width_dbl = width << 1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_LOAD;
      count     <= '0;
      ovf       <= 1'b0;
      sel       <= 1'b0;
      pend_i    <= 1'b0;
      pend_j    <= 1'b0;
      emit_v    <= 1'b0;
      emit_last <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      ovf       <= ovf_next;
      sel       <= sel_next;
      pend_i    <= pend_i_next;
      pend_j    <= pend_j_next;
      emit_v    <= emit_v_next;
      emit_last <= emit_last_next;
    end
    width  <= width_next;
    lo     <= lo_next;
    mid    <= mid_next;
    hi     <= hi_next;
    i      <= i_next;
    j      <= j_next;
    k      <= k_next;
    head_i <= head_i_next;
    head_j <= head_j_next;
  end

  always_comb begin
    state_next     = state;
    count_next     = count;
    ovf_next       = ovf;
    sel_next       = sel;
    width_next     = width;
    lo_next        = lo;
    mid_next       = mid;
    hi_next        = hi;
    i_next         = i;
    j_next         = j;
    k_next         = k;
    head_i_next    = head_i;
    head_j_next    = head_j;
    pend_i_next    = pend_i;
    pend_j_next    = pend_j;
    emit_v_next    = 1'b0;
    emit_last_next = 1'b0;
    we0            = 1'b0;
    we1            = 1'b0;
    waddr          = k[AW-1:0];
    wdata          = value;
    raddr          = k[AW-1:0];

    case (state)
      S_LOAD: begin
        waddr = count[AW-1:0];
        if (accept) begin
          if (count < CW'(MAX_ITEMS)) begin
            we0        = 1'b1;
            count_next = count + 1'b1;
          end else begin
            ovf_next = 1'b1;
          end
          if (last_in) begin
            sel_next   = 1'b0;
            width_next = XW'(1);
            lo_next    = '0;
            k_next     = '0;
            if (count_next > CW'(1)) begin
              state_next = S_SETUP_I;
            end else begin
              state_next = S_EMIT;
            end
          end
        end
      end

      S_SETUP_I: begin
        mid_next    = (sum_mid > XW'(count)) ? count : sum_mid[CW-1:0];
        hi_next     = (sum_hi > XW'(count)) ? count : sum_hi[CW-1:0];
        i_next      = lo;
        j_next      = mid_next;
        k_next      = lo;
        raddr       = lo[AW-1:0];
        pend_i_next = 1'b0;
        pend_j_next = 1'b0;
        state_next  = S_SETUP_J;
      end

      S_SETUP_J: begin
        head_i_next = rd_src;
        raddr       = j[AW-1:0];
        pend_j_next = j_left;
        state_next  = S_MERGE;
      end

      S_MERGE: begin
        we0         = sel;
        we1         = !sel;
        wdata       = take_i ? eff_i : eff_j;
        head_i_next = eff_i;
        head_j_next = eff_j;
        pend_i_next = 1'b0;
        pend_j_next = 1'b0;
        k_next      = k + 1'b1;
        if (take_i) begin
          i_next = i + 1'b1;
          raddr  = i_next[AW-1:0];
          if (i_next < mid) begin
            pend_i_next = 1'b1;
          end
        end else begin
          j_next = j + 1'b1;
          raddr  = j_next[AW-1:0];
          if (j_next < hi) begin
            pend_j_next = 1'b1;
          end
        end
        if (k_next == hi) begin
          if (next_lo >= XW'(count)) begin
            sel_next   = !sel;
            width_next = width_dbl;
            lo_next    = '0;
            k_next     = '0;
            if (width_dbl >= XW'(count)) begin
              state_next = S_EMIT;
            end else begin
              state_next = S_SETUP_I;
            end
          end else begin
            lo_next    = next_lo[CW-1:0];
            state_next = S_SETUP_I;
          end
        end
      end

      S_EMIT: begin
        raddr          = k[AW-1:0];
        emit_v_next    = 1'b1;
        k_next         = k + 1'b1;
        emit_last_next = (k_next == count);
        if (k_next == count) begin
          state_next = S_DRAIN;
        end
      end

      S_DRAIN: begin
        count_next = '0;
        ovf_next   = 1'b0;
        state_next = S_LOAD;
      end

      default: begin
        state_next = S_LOAD;
      end
    endcase
  end

  a_strobe_busy: assert property (@(posedge clk) disable iff (rst)
    strobe |-> busy)
    else $error("result beat while idle");

  a_one_pending: assert property (@(posedge clk) disable iff (rst)
    !(pend_i && pend_j))
    else $error("both merge heads waiting on the read port");

  a_merge_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_MERGE) |-> (k < hi) && (i_left || j_left))
    else $error("merge write past end of run");

  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(MAX_ITEMS))
    else $error("item count beyond capacity");

  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    (strobe && last_out) |=> (state == S_LOAD) && !strobe)
    else $error("final beat not followed by return to load");

endmodule

`default_nettype wire

// ===== dv/merge_sort_unit_check.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// merge_sort_unit_check
// watches both channels of the merge sort unit and checks every result beat
// lists are rebuilt from accepted input beats, sorted ascending when the last
// beat lands, and each result beat is compared against the oldest queued word
// ----------------------------------------------------------------------------

module merge_sort_unit_check #(
  parameter int unsigned MAX_ITEMS = 64
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  logic           busy,
  input  msu_pkg::data_t value,
  input  logic           last_in,
  input  logic           strobe,
  input  msu_pkg::data_t sorted_value,
  input  logic           last_out,
  input  logic           overflow,
  output int             errors,
  output int             pending,
  output int             checked
);

  import msu_pkg::*;

  typedef struct {
    data_t word;
    logic  last;
    logic  ovf;
  } sorted_word_t;

  sorted_word_t sorted_q[$];
  sorted_word_t head;
  data_t        list_buf[MAX_ITEMS];
  int unsigned  fill;
  logic         dropped;

  assign pending = sorted_q.size();

  // ascending order of the buffered list, queued with end and overflow flags
  function automatic void queue_sorted_list();
    int           i;
    int           j;
    data_t        key;
    sorted_word_t w;
    for (i = 1; i < int'(fill); i++) begin
      key = list_buf[i];
      j = i - 1;
      while (j >= 0 && list_buf[j] > key) begin
        list_buf[j + 1] = list_buf[j];
        j--;
      end
      list_buf[j + 1] = key;
    end
    for (i = 0; i < int'(fill); i++) begin
      w.word = list_buf[i];
      w.last = (i == int'(fill) - 1);
      w.ovf  = dropped;
      sorted_q.push_back(w);
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      sorted_q.delete();
      fill    = 0;
      dropped = 1'b0;
      errors  = 0;
      checked = 0;
    end else begin
      if (strobe) begin
        if (sorted_q.size() == 0) begin
          $display("%0t: unexpected result beat, expected none, got %0d last %0b ovf %0b",
                   $time, sorted_value, last_out, overflow);
          errors++;
        end else begin
          head = sorted_q.pop_front();
          checked++;
          if (sorted_value !== head.word) begin
            $display("%0t: sorted_value expected %0d, got %0d", $time, head.word,
                     sorted_value);
            errors++;
          end
          if (last_out !== head.last) begin
            $display("%0t: last_out expected %0b, got %0b", $time, head.last, last_out);
            errors++;
          end
          if (overflow !== head.ovf) begin
            $display("%0t: overflow expected %0b, got %0b", $time, head.ovf, overflow);
            errors++;
          end
        end
      end
      if (start && !busy) begin
        if (fill < MAX_ITEMS) begin
          list_buf[fill] = value;
          fill++;
        end else begin
          dropped = 1'b1;
        end
        if (last_in) begin
          queue_sorted_list();
          fill    = 0;
          dropped = 1'b0;
        end
      end
    end
  end

endmodule

// ===== dv/merge_sort_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// merge_sort_unit_tb
// stimulus and verdict for the merge sort unit
// a few hand-picked lists (extreme words, single words, ties, reversed and
// presorted order) are followed by random lists of mixed length, including
// full and over-capacity lists, with random gaps between beats
// ----------------------------------------------------------------------------

module merge_sort_unit_tb;
  import msu_pkg::*;

  localparam int unsigned MAX_ITEMS    = 64;
  localparam int unsigned RANDOM_BEATS = 430;
  localparam int          CYCLE_LIMIT  = 300000;
  localparam int          DRAIN_CYCLES = 40;

  logic  clk;
  logic  rst;
  logic  start;
  logic  busy;
  data_t value;
  logic  last_in;
  logic  strobe;
  data_t sorted_value;
  logic  last_out;
  logic  overflow;

  int fail_count;
  int pending;
  int checked;
  int cycles = 0;
  int n_beats;
  int n_lists;
  int n_overfull;

  merge_sort_unit #(
    .MAX_ITEMS(MAX_ITEMS)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .value(value),
    .last_in(last_in),
    .strobe(strobe),
    .sorted_value(sorted_value),
    .last_out(last_out),
    .overflow(overflow)
  );

  merge_sort_unit_check #(
    .MAX_ITEMS(MAX_ITEMS)
  ) i_check (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .value(value),
    .last_in(last_in),
    .strobe(strobe),
    .sorted_value(sorted_value),
    .last_out(last_out),
    .overflow(overflow),
    .errors(fail_count),
    .pending(pending),
    .checked(checked)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("%0t: run did not finish within %0d cycles", $time, CYCLE_LIMIT);
      $display("Verification failed");
      $finish;
    end
  end

  function automatic int unsigned idle_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // 0: any word, 1: narrow range for ties, 2: extremes, else a mix per word
  function automatic data_t rand_word(input int unsigned mode);
    int unsigned pick;
    pick = (mode > 2) ? $urandom_range(0, 2) : mode;
    case (pick)
      0: return data_t'($urandom);
      1: return data_t'(int'($urandom_range(0, 16)) - 8);
      default: begin
        case ($urandom_range(0, 3))
          0: return data_t'(32'h7fff_ffff);
          1: return data_t'(32'h8000_0000);
          2: return data_t'(32'h0000_0000);
          default: return data_t'(32'hffff_ffff);
        endcase
      end
    endcase
  endfunction

  task automatic send_beat(input data_t v, input logic fin, input int unsigned gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start   <= 1'b1;
    value   <= v;
    last_in <= fin;
    @(posedge clk);
    while (busy) @(posedge clk);
    n_beats++;
    if (fin) n_lists++;
  endtask

  task automatic send_random_list(input int unsigned len);
    int unsigned mode;
    bit          steady;
    int unsigned i;
    mode   = $urandom_range(0, 3);
    steady = ($urandom_range(0, 3) == 0);
    if (len > MAX_ITEMS) n_overfull++;
    for (i = 0; i < len; i++) begin
      send_beat(rand_word(mode), i == len - 1, steady ? 0 : idle_gap());
    end
  endtask

  initial begin
    int unsigned len;
    int unsigned r;
    int unsigned start_beats;
    n_beats    = 0;
    n_lists    = 0;
    n_overfull = 0;
    rst     <= 1'b1;
    start   <= 1'b0;
    value   <= '0;
    last_in <= 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // extremes in scrambled order
    send_beat(data_t'(32'h7fff_ffff), 1'b0, 0);
    send_beat(data_t'(32'h8000_0000), 1'b0, 0);
    send_beat(data_t'(0), 1'b0, 1);
    send_beat(data_t'(-1), 1'b0, 0);
    send_beat(data_t'(1), 1'b0, 0);
    send_beat(data_t'(32'h4000_0000), 1'b0, 2);
    send_beat(data_t'(-2), 1'b1, 0);
    // single-word lists
    send_beat(data_t'(32'h8000_0000), 1'b1, 0);
    send_beat(data_t'(32'h7fff_ffff), 1'b1, 3);
    // ties
    send_beat(data_t'(5), 1'b0, 0);
    send_beat(data_t'(5), 1'b0, 0);
    send_beat(data_t'(-5), 1'b0, 0);
    send_beat(data_t'(5), 1'b0, 0);
    send_beat(data_t'(-5), 1'b1, 0);
    // reversed pair, then presorted
    send_beat(data_t'(100), 1'b0, 0);
    send_beat(data_t'(-100), 1'b1, 0);
    send_beat(data_t'(1), 1'b0, 0);
    send_beat(data_t'(2), 1'b0, 0);
    send_beat(data_t'(3), 1'b1, 0);

    start_beats = n_beats;
    send_random_list(MAX_ITEMS);
    send_random_list(MAX_ITEMS + 1);
    while (n_beats - start_beats < RANDOM_BEATS) begin
      r = $urandom_range(0, 99);
      if (r < 65) len = $urandom_range(1, 12);
      else if (r < 82) len = $urandom_range(13, MAX_ITEMS - 1);
      else if (r < 91) len = MAX_ITEMS;
      else len = $urandom_range(MAX_ITEMS + 1, MAX_ITEMS + 6);
      send_random_list(len);
    end
    start <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d input beats in %0d lists, %0d of them past capacity", n_beats, n_lists,
             n_overfull);
    $display("%0d sorted result beats compared, %0d errors", checked, fail_count);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/msu_pkg.sv
rtl/msu_ram.sv
rtl/merge_sort_unit.sv
dv/merge_sort_unit_check.sv
dv/merge_sort_unit_tb.sv
